[hdl/wsc_pkg.sv]
`default_nettype none

package wsc_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int MAX_WINDOW  = 128;
    localparam int POS_BITS    = $clog2(MAX_WINDOW);
    localparam int LEN_BITS    = 8;
    localparam int PERIOD_BITS = 16;
    localparam int CROSS_BITS  = 7;
    localparam int CFG_BITS    = 10;

    localparam int IN_TDATA_BITS  = 16;
    localparam int OUT_TDATA_BITS = 40;

    localparam logic [LEN_BITS-1:0]    LEN_MIN       = 8'd2;
    localparam logic [LEN_BITS-1:0]    LEN_MAX       = 8'(MAX_WINDOW);
    localparam logic [LEN_BITS-1:0]    LEN_RESET     = 8'd100;
    localparam logic [SAMPLE_BITS-1:0] MID_RESET     = 10'd512;
    localparam logic [SAMPLE_BITS-1:0] SLOPE_RESET   = 10'd50;
    localparam logic [PERIOD_BITS-1:0] PERIOD_SAT    = 16'hFFFF;
    localparam logic [CROSS_BITS-1:0]  CROSS_MIN_CLS = 7'd2;

    typedef enum logic [1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_MID_LEVEL     = 2'd1,
        CFG_SLOPE_LIMIT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        WC_UNKNOWN  = 2'd0,
        WC_SQUARE   = 2'd1,
        WC_TRIANGLE = 2'd2,
        WC_SINE     = 2'd3
    } t_wave_class;

endpackage

`default_nettype wire

[hdl/waveform_shape_classifier.sv]
// result: registered in the cycle after the accepted beat that closes a window
// throughput: one sample beat per cycle; beats that do not close a window give no result
// the input is taken whenever the result register is empty or being drained
// reset: i_rst_n synchronous, active low; registers return to 100 / 512 / 50,
// window state and the crossing counter clear, the result register empties
`default_nettype none

module waveform_shape_classifier
    import wsc_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [1:0]                  i_cfg_idx,
    input  wire [CFG_BITS-1:0]         i_cfg_data,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // [9:0] sample, [15:10] zero
    input  wire [IN_TDATA_BITS-1:0]    s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // [1:0] wave_class, [11:2] peak_code, [27:12] period_samples,
    // [34:28] crossing_count, [39:35] zero
    output logic [OUT_TDATA_BITS-1:0]  m_axis_tdata
);

    logic [LEN_BITS-1:0]    r_window_length;
    logic [SAMPLE_BITS-1:0] r_mid_level;
    logic [SAMPLE_BITS-1:0] r_slope_limit;

    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic [SAMPLE_BITS-1:0] r_prev_sample;
    logic [SAMPLE_BITS-1:0] r_prev_step, n_prev_step;
    logic [SAMPLE_BITS-1:0] r_peak, n_peak;
    logic [SAMPLE_BITS-1:0] r_largest, n_largest;
    logic [CROSS_BITS-1:0]  r_flat, n_flat;
    logic                   r_all_equal, n_all_equal;
    logic [CROSS_BITS-1:0]  r_cross, n_cross;
    logic [PERIOD_BITS-1:0] r_since, n_since;
    logic [PERIOD_BITS-1:0] r_period, n_period;

    logic                      r_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_data, n_out_data;

    logic                   w_accept;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [LEN_BITS-1:0]    w_len;
    logic                   w_first;
    logic                   w_last;
    logic                   w_s_high, w_p_high, w_rising;
    logic [SAMPLE_BITS-1:0] w_step;
    logic [PERIOD_BITS-1:0] w_cnt;
    t_wave_class            w_class;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_sample      = s_axis_tdata[SAMPLE_BITS-1:0];
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        if (r_window_length < LEN_MIN) begin
            w_len = LEN_MIN;
        end else if (r_window_length > LEN_MAX) begin
            w_len = LEN_MAX;
        end else begin
            w_len = r_window_length;
        end
    end

    always_comb begin
        w_first  = (r_pos == '0);
        w_last   = ((LEN_BITS'(r_pos) + LEN_BITS'(1)) >= w_len);
        w_s_high = (w_sample >= r_mid_level);
        w_p_high = (r_prev_sample >= r_mid_level);
        w_rising = !w_p_high && w_s_high;
        w_step   = (w_sample >= r_prev_sample) ? (w_sample - r_prev_sample)
                                               : (r_prev_sample - w_sample);
        w_cnt    = (r_since != PERIOD_SAT) ? (r_since + PERIOD_BITS'(1)) : PERIOD_SAT;

        // a new window starts from cleared statistics
        n_peak      = w_first ? '0 : r_peak;
        n_largest   = w_first ? '0 : r_largest;
        n_flat      = w_first ? '0 : r_flat;
        n_all_equal = w_first ? 1'b1 : r_all_equal;
        n_cross     = w_first ? '0 : r_cross;
        n_period    = w_first ? '0 : r_period;
        n_prev_step = w_first ? '0 : r_prev_step;

        if (w_sample > n_peak) begin
            n_peak = w_sample;
        end

        if (w_rising) begin
            n_period = w_cnt;
            n_since  = '0;
        end else begin
            n_since  = w_cnt;
        end

        if (!w_first) begin
            if (w_step > n_largest) begin
                n_largest = w_step;
            end
            if (w_step == '0) begin
                n_flat = n_flat + CROSS_BITS'(1);
            end
            if ((r_pos != POS_BITS'(1)) && (w_step != n_prev_step)) begin
                n_all_equal = 1'b0;
            end
            n_prev_step = w_step;
            if (w_s_high != w_p_high) begin
                n_cross = n_cross + CROSS_BITS'(1);
            end
        end

        n_pos = w_last ? '0 : (r_pos + POS_BITS'(1));

        if (LEN_BITS'(n_flat) > (w_len >> 1)) begin
            w_class = WC_SQUARE;
        end else if (n_all_equal && (n_cross >= CROSS_MIN_CLS)) begin
            w_class = WC_TRIANGLE;
        end else if ((n_cross >= CROSS_MIN_CLS) && (n_largest > r_slope_limit)
                     && !n_all_equal) begin
            w_class = WC_SINE;
        end else begin
            w_class = WC_UNKNOWN;
        end

        n_out_data = {5'b0, n_cross, n_period, n_peak, w_class};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= LEN_RESET;
            r_mid_level     <= MID_RESET;
            r_slope_limit   <= SLOPE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data[LEN_BITS-1:0];
                CFG_MID_LEVEL:     r_mid_level     <= i_cfg_data;
                CFG_SLOPE_LIMIT:   r_slope_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_prev_sample <= '0;
            r_prev_step   <= '0;
            r_peak        <= '0;
            r_largest     <= '0;
            r_flat        <= '0;
            r_all_equal   <= 1'b1;
            r_cross       <= '0;
            r_since       <= '0;
            r_period      <= '0;
        end else if (w_accept) begin
            r_pos         <= n_pos;
            r_prev_sample <= w_sample;
            r_prev_step   <= n_prev_step;
            r_peak        <= n_peak;
            r_largest     <= n_largest;
            r_flat        <= n_flat;
            r_all_equal   <= n_all_equal;
            r_cross       <= n_cross;
            r_since       <= n_since;
            r_period      <= n_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

[hdl/wsc_checker.sv]
`default_nettype none

module wsc_checker
    import wsc_pkg::*;
(
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       s_axis_tready,
    input wire                       m_axis_tvalid,
    input wire                       m_axis_tready,
    input wire [OUT_TDATA_BITS-1:0]  m_axis_tdata
);

    // a stalled result holds its beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // a full result register that is not drained blocks the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while result stalled");

    // triangle and sine need at least two crossings
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == WC_TRIANGLE || m_axis_tdata[1:0] == WC_SINE)
        |-> m_axis_tdata[34:28] >= CROSS_MIN_CLS)
        else $error("class without enough crossings");

    // padding above crossing_count stays zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_BITS-1:35] == '0)
        else $error("padding bits set");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind waveform_shape_classifier wsc_checker u_wsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
